@@ sv/tremolo_lfo_gain_core_macros.svh @@
// Assertion helpers for the tremolo core; tlg_back uses them.
`ifndef TREMOLO_LFO_GAIN_CORE_MACROS_SVH
`define TREMOLO_LFO_GAIN_CORE_MACROS_SVH

// Condition c must hold in the same cycle as a.
`define TLG_ASSERT_SAME(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Condition c must hold in the cycle after a.
`define TLG_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

@@ sv/tlg_pkg.sv @@
package tlg_pkg;

    // Sine table resolution in phase bits (valid range 6 to 12).
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_QUARTER    = 1 << (SINE_TABLE_BITS - 2);

    localparam logic [63:0] Q30_ONE    = 64'd1073741824;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    localparam int SAMPLE_W = 16;
    localparam int LFO_W    = 9;
    localparam int DEPTH_W  = 12;
    localparam int GAIN_W   = 15;
    localparam int PHASE_W  = 32;

    localparam logic signed [LFO_W-1:0] LFO_PEAK = 9'sd255;
    localparam int GAIN_SHIFT  = 5;
    localparam int SCALE_SHIFT = 15;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_PHASE_INC = 2'd0;
    localparam logic [1:0] REG_DEPTH     = 2'd1;
    localparam logic [1:0] REG_WAVEFORM  = 2'd2;

    // Waveform codes; the unused code behaves as the square.
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [1:0] WAVE_SQUARE   = 2'd2;

    localparam logic [PHASE_W-1:0]  PHASE_INC_RESET = 32'd447000;
    localparam logic [DEPTH_W-1:0]  DEPTH_RESET     = 12'd2048;
    localparam logic [1:0]          WAVEFORM_RESET  = WAVE_SINE;

    // Depth of the queue between front and back; a power of two.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [LFO_W-1:0]    lfo;
    } item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_GAIN,
        BK_CLAMP,
        BK_SCALE,
        BK_OUT
    } back_state_t;

    typedef logic [7:0] sine_rom_t [SINE_QUARTER];

    // round(255*sin(2*pi*m/2^SINE_TABLE_BITS)) by a fixed-point Taylor series.
    // Only evaluated at elaboration to build the constant table.
    function automatic logic [7:0] quarter_sine(input logic [SINE_TABLE_BITS-2:0] m);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        logic               neg;
        x    = (TWO_PI_Q30 * 64'(m)) >> SINE_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        neg  = 1'b1;
        for (int n = 2; n <= 20; n += 2) begin
            term = ((term * x2) >> 30) / 64'(n * (n + 1));
            if (neg)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
            neg = !neg;
        end
        if (sum < 0)
            sum = 64'sd0;
        if (sum > $signed(Q30_ONE))
            sum = $signed(Q30_ONE);
        rnd = (($unsigned(sum) * 64'd255) + (Q30_ONE >> 1)) >> 30;
        return rnd[7:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < SINE_QUARTER; i++)
            rom[i] = quarter_sine((SINE_TABLE_BITS - 1)'(i));
        return rom;
    endfunction

    localparam sine_rom_t  SINE_ROM  = build_sine_rom();
    localparam logic [7:0] SINE_PEAK = quarter_sine((SINE_TABLE_BITS - 1)'(SINE_QUARTER));

endpackage

@@ sv/tremolo_lfo_gain_core.sv @@
// Tremolo core: each signed 16-bit audio item pushed in advances a 32-bit LFO
// phase by phase_increment, picks a sine, triangle or square LFO value in
// -255..255 from the new phase, and comes out as (sample * gain) >> 15 with
// gain = 32767 - ((depth * (255 - lfo)) >> 5), clamped at 0, together with the
// LFO value used. Both sides behave as queues: an item is taken when push is
// high and full is low, and a result is taken when pop is high and empty is
// low. The front end holds each item it takes in a staging register, and a
// two-entry queue lets it keep taking items while the back end is busy. The
// back end shares a single multiplier between the depth product and the sample
// product, so it steps each item through GAIN, CLAMP, SCALE and OUT and takes
// no new item from the queue before OUT; this sets the sustained rate.
// Configuration registers (phase_increment, depth, waveform) are written on a
// separate valid/ready port that is always ready; they should only be changed
// while no item is in flight.
module tremolo_lfo_gain_core (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  push,
    output logic                                  full,
    input  logic signed [tlg_pkg::SAMPLE_W-1:0]   sample_in,

    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [tlg_pkg::SAMPLE_W-1:0]   sample_out,
    output logic signed [tlg_pkg::LFO_W-1:0]      lfo_value,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [31:0]                           cfg_data
);

    logic [tlg_pkg::PHASE_W-1:0]  phase_inc_reg;
    logic [tlg_pkg::DEPTH_W-1:0]  depth_reg;
    logic [1:0]                   waveform_reg;
    logic                         cfg_write;

    // Front end to queue, and queue to back end.
    logic                         q_push;
    logic                         q_full;
    tlg_pkg::item_t               q_wdata;
    logic                         q_pop;
    logic                         q_empty;
    tlg_pkg::item_t               q_rdata;

    // The register file never stalls a write.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // A write to the unused index is simply dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg <= tlg_pkg::PHASE_INC_RESET;
            depth_reg     <= tlg_pkg::DEPTH_RESET;
            waveform_reg  <= tlg_pkg::WAVEFORM_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tlg_pkg::REG_PHASE_INC: phase_inc_reg <= cfg_data;
                tlg_pkg::REG_DEPTH:     depth_reg     <= cfg_data[tlg_pkg::DEPTH_W-1:0];
                tlg_pkg::REG_WAVEFORM:  waveform_reg  <= cfg_data[1:0];
                default:
                begin
                    phase_inc_reg <= phase_inc_reg;
                end
            endcase
        end
    end

    // The front end holds the phase accumulator and forms the LFO value for
    // the item it has staged.
    tlg_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .sample_in       (sample_in),
        .full            (full),
        .phase_increment (phase_inc_reg),
        .waveform        (waveform_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_item          (q_wdata)
    );

    // Short queue so that front and back end stall independently.
    tlg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_rdata (q_rdata),
        .q_empty (q_empty)
    );

    // The back end computes the gain and the scaled sample, and holds the
    // result in an output register until it is popped.
    tlg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .depth      (depth_reg),
        .q_empty    (q_empty),
        .q_item     (q_rdata),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .sample_out (sample_out),
        .lfo_value  (lfo_value)
    );

endmodule

@@ sv/tlg_front.sv @@
module tlg_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    input  logic signed [tlg_pkg::SAMPLE_W-1:0]    sample_in,
    output logic                                   full,
    input  logic [tlg_pkg::PHASE_W-1:0]            phase_increment,
    input  logic [1:0]                             waveform,
    input  logic                                   q_full,
    output logic                                   q_push,
    output tlg_pkg::item_t                         q_item
);

    localparam int KB = tlg_pkg::SINE_TABLE_BITS;
    localparam int JB = KB - 2;

    logic [tlg_pkg::PHASE_W-1:0]         phase_reg;
    logic [tlg_pkg::PHASE_W-1:0]         phase_next;
    logic                                stage_valid_reg;
    logic                                stage_valid_next;
    logic signed [tlg_pkg::SAMPLE_W-1:0] stage_sample_reg;
    logic                                accept;

    logic [KB-1:0]                       k;
    logic [1:0]                          quad;
    logic [JB-1:0]                       j;
    logic [JB-1:0]                       j_mirror;
    logic [7:0]                          sine_mag;
    logic [7:0]                          tri_p;
    logic signed [tlg_pkg::LFO_W-1:0]    sine_val;
    logic signed [tlg_pkg::LFO_W-1:0]    tri_val;
    logic signed [tlg_pkg::LFO_W-1:0]    lfo;

    assign full   = stage_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = stage_valid_reg && !q_full;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        phase_next       = phase_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
            phase_next       = phase_reg + phase_increment;
        end
        else if (q_push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_sample_reg <= sample_in;
    end

    // The staged item's phase is phase_reg until the next item is taken.
    always_comb
    begin
        k        = phase_reg[tlg_pkg::PHASE_W-1 -: KB];
        quad     = k[KB-1:KB-2];
        j        = k[JB-1:0];
        j_mirror = JB'(0) - j;
        if (quad[0])
        begin
            if (j == '0)
                sine_mag = tlg_pkg::SINE_PEAK;
            else
                sine_mag = tlg_pkg::SINE_ROM[j_mirror];
        end
        else
        begin
            sine_mag = tlg_pkg::SINE_ROM[j];
        end
        sine_val = quad[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

        tri_p = phase_reg[29:22];
        case (phase_reg[31:30])
            2'd0:    tri_val = $signed({1'b0, tri_p});
            2'd1:    tri_val = tlg_pkg::LFO_PEAK - $signed({1'b0, tri_p});
            2'd2:    tri_val = -$signed({1'b0, tri_p});
            default: tri_val = $signed({1'b0, tri_p}) - tlg_pkg::LFO_PEAK;
        endcase

        case (waveform)
            tlg_pkg::WAVE_SINE:     lfo = sine_val;
            tlg_pkg::WAVE_TRIANGLE: lfo = tri_val;
            default:                lfo = phase_reg[31] ? -tlg_pkg::LFO_PEAK : tlg_pkg::LFO_PEAK;
        endcase
    end

    assign q_item.sample = stage_sample_reg;
    assign q_item.lfo    = lfo;

endmodule

@@ sv/tlg_queue.sv @@
module tlg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_push,
    input  tlg_pkg::item_t q_wdata,
    output logic           q_full,
    input  logic           q_pop,
    output tlg_pkg::item_t q_rdata,
    output logic           q_empty
);

    tlg_pkg::item_t                  mem [tlg_pkg::QDEPTH];
    logic [tlg_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [tlg_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [tlg_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [tlg_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [tlg_pkg::QPTR_W:0]        count_reg;
    logic [tlg_pkg::QPTR_W:0]        count_next;
    logic                            do_push;
    logic                            do_pop;

    assign q_full  = (count_reg == (tlg_pkg::QPTR_W + 1)'(tlg_pkg::QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && !q_empty;
    assign q_rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= q_wdata;
    end

endmodule

@@ sv/tlg_back.sv @@
`include "tremolo_lfo_gain_core_macros.svh"

module tlg_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [tlg_pkg::DEPTH_W-1:0]           depth,
    input  logic                                  q_empty,
    input  tlg_pkg::item_t                        q_item,
    output logic                                  q_pop,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [tlg_pkg::SAMPLE_W-1:0]   sample_out,
    output logic signed [tlg_pkg::LFO_W-1:0]      lfo_value
);

    tlg_pkg::back_state_t                 state_reg;
    tlg_pkg::back_state_t                 state_next;
    tlg_pkg::item_t                       item_reg;
    logic signed [32:0]                   mul_reg;
    logic [tlg_pkg::GAIN_W-1:0]           gain_reg;
    logic [tlg_pkg::GAIN_W-1:0]           gain_next;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic signed [tlg_pkg::SAMPLE_W-1:0]  out_sample_reg;
    logic signed [tlg_pkg::LFO_W-1:0]     out_lfo_reg;

    logic                                 out_free;
    logic                                 start;
    logic                                 out_load;
    logic                                 mul_load;
    logic signed [16:0]                   mul_a;
    logic signed [15:0]                   mul_b;
    logic signed [32:0]                   mul_p;
    logic signed [10:0]                   lfo_inv;
    logic [16:0]                          shr;
    logic signed [17:0]                   diff;

    assign out_free = !out_valid_reg || pop;
    assign start    = !q_empty
                      && (state_reg == tlg_pkg::BK_IDLE
                          || (state_reg == tlg_pkg::BK_OUT && out_free));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlg_pkg::BK_IDLE:  if (start) state_next = tlg_pkg::BK_GAIN;
            tlg_pkg::BK_GAIN:  state_next = tlg_pkg::BK_CLAMP;
            tlg_pkg::BK_CLAMP: state_next = tlg_pkg::BK_SCALE;
            tlg_pkg::BK_SCALE: state_next = tlg_pkg::BK_OUT;
            tlg_pkg::BK_OUT:
            begin
                if (start)
                    state_next = tlg_pkg::BK_GAIN;
                else if (out_free)
                    state_next = tlg_pkg::BK_IDLE;
            end
            default:           state_next = tlg_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = start;
        out_load = (state_reg == tlg_pkg::BK_OUT) && out_free;
        mul_load = 1'b0;
        lfo_inv  = 11'sd255 - 11'(item_reg.lfo);
        mul_a    = 17'(signed'({1'b0, depth}));
        mul_b    = 16'(lfo_inv);
        case (state_reg)
            tlg_pkg::BK_GAIN:
            begin
                mul_load = 1'b1;
            end
            tlg_pkg::BK_SCALE:
            begin
                mul_load = 1'b1;
                mul_a    = 17'(item_reg.sample);
                mul_b    = $signed({1'b0, gain_reg});
            end
            default:
            begin
                mul_load = 1'b0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // depth*(255-lfo) stays below 2^21, so the shifted value fits 17 bits.
    always_comb
    begin
        shr       = mul_reg[21:tlg_pkg::GAIN_SHIFT];
        diff      = 18'sd32767 - $signed({1'b0, shr});
        gain_next = (diff < 0) ? '0 : diff[tlg_pkg::GAIN_W-1:0];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlg_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            item_reg <= q_item;
        if (mul_load)
            mul_reg <= mul_p;
        if (state_reg == tlg_pkg::BK_CLAMP)
            gain_reg <= gain_next;
        if (out_load)
        begin
            out_sample_reg <= mul_reg[tlg_pkg::SCALE_SHIFT + tlg_pkg::SAMPLE_W - 1:
                                      tlg_pkg::SCALE_SHIFT];
            out_lfo_reg    <= item_reg.lfo;
        end
    end

    assign empty      = !out_valid_reg;
    assign sample_out = out_sample_reg;
    assign lfo_value  = out_lfo_reg;

    `TLG_ASSERT_SAME(a_pop_needs_item, clk, rst_n, q_pop, !q_empty, "queue popped while empty")
    `TLG_ASSERT_SAME(a_gain_product_nonneg, clk, rst_n, state_reg == tlg_pkg::BK_CLAMP, mul_reg >= 0, "negative depth product")
    `TLG_ASSERT_NEXT(a_result_waits, clk, rst_n, state_reg == tlg_pkg::BK_OUT && out_valid_reg && !pop, state_reg == tlg_pkg::BK_OUT, "result overwrote a waiting item")
    `TLG_ASSERT_NEXT(a_scale_follows_clamp, clk, rst_n, state_reg == tlg_pkg::BK_CLAMP, state_reg == tlg_pkg::BK_SCALE, "clamp not followed by scale")

endmodule
